@@ rtl/mcg_pkg.sv @@
package mcg_pkg;

    // Register map of the configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PLAY_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_ENABLE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BEAT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_LENGTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP       = 3'd5;

    // Field and state widths
    localparam int SPB_W    = 20;
    localparam int BURST_W  = 12;
    localparam int SCALE_W  = 16;
    localparam int STEP_W   = 32;
    localparam int CD_W     = 22;
    localparam int SINE_W   = 15;
    localparam int ENV_W    = 17;
    localparam int SAMPLE_W = 15;
    localparam int MAG_W    = 14;

    // Register reset values
    localparam logic [SPB_W-1:0]   SPB_RESET   = 20'd24000;
    localparam logic [BURST_W-1:0] BURST_RESET = 12'd384;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd171;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 32'd89478485;

    // Envelope ceiling (1.0 in Q16)
    localparam logic [ENV_W-1:0] ENV_ONE = 17'h10000;

    // Table construction constants, Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef struct packed {
        logic               play_enable;
        logic               click_enable;
        logic [SPB_W-1:0]   samples_per_beat;
        logic [BURST_W-1:0] burst_length;
        logic [SCALE_W-1:0] envelope_scale;
        logic [STEP_W-1:0]  phase_step;
    } cfg_t;

endpackage

@@ rtl/mcg_sine_rom.sv @@
module mcg_sine_rom #(
    parameter int unsigned DEPTH = 256,
    localparam int AW = $clog2(DEPTH) + 1
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [AW-1:0]                   addr,
    output logic [mcg_pkg::SINE_W-1:0]      data
);

    typedef logic [mcg_pkg::SINE_W-1:0] rom_t [DEPTH+1];

    // One quarter-wave entry: Taylor series in Q30, rounded half up to Q15
    function automatic logic [mcg_pkg::SINE_W-1:0] sine_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] q;
        longint      sum;
        x    = (mcg_pkg::HALF_PI_Q30 * 64'(i)) / DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > longint'(mcg_pkg::ONE_Q30))
        begin
            sum = longint'(mcg_pkg::ONE_Q30);
        end
        q = (64'(sum) + 64'd16384) >> 15;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        return q[mcg_pkg::SINE_W-1:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t t;
        for (int unsigned i = 0; i <= DEPTH; i++)
        begin
            t[i] = sine_entry(i);
        end
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [mcg_pkg::SINE_W-1:0] data_reg;

    // Registered read, held between enables
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

@@ rtl/mcg_serial_mul.sv @@
module mcg_serial_mul #(
    parameter int AW = 16,
    parameter int BW = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [AW-1:0]   a,
    input  logic [BW-1:0]   b,
    output logic            done,
    output logic [AW+BW-1:0] product
);

    localparam int PW = AW + BW;
    localparam int CW = (BW > 1) ? $clog2(BW) : 1;

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [PW-1:0] acc_reg;
    logic [PW-1:0] acc_next;
    logic [PW-1:0] a_sh_reg;
    logic [PW-1:0] a_sh_next;
    logic [BW-1:0] b_sh_reg;
    logic [BW-1:0] b_sh_next;

    // Shift-add: one multiplier bit per cycle, LSB first
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            a_sh_next = PW'(a);
            b_sh_next = b;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + (b_sh_reg[0] ? a_sh_reg : '0);
            a_sh_next = a_sh_reg << 1;
            b_sh_next = b_sh_reg >> 1;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CW'(BW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ rtl/mcg_cfg_regs.sv @@
module mcg_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mcg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcg_pkg::CFG_DATA_W-1:0]     cfg_data,
    output mcg_pkg::cfg_t                      cfg
);

    mcg_pkg::cfg_t cfg_reg;
    mcg_pkg::cfg_t cfg_next;

    // Decode the register index of a write beat
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                mcg_pkg::REG_PLAY_ENABLE:
                    cfg_next.play_enable = cfg_data[0];
                mcg_pkg::REG_CLICK_ENABLE:
                    cfg_next.click_enable = cfg_data[0];
                mcg_pkg::REG_SAMPLES_PER_BEAT:
                    cfg_next.samples_per_beat = cfg_data[mcg_pkg::SPB_W-1:0];
                mcg_pkg::REG_BURST_LENGTH:
                    cfg_next.burst_length = cfg_data[mcg_pkg::BURST_W-1:0];
                mcg_pkg::REG_ENVELOPE_SCALE:
                    cfg_next.envelope_scale = cfg_data[mcg_pkg::SCALE_W-1:0];
                mcg_pkg::REG_PHASE_STEP:
                    cfg_next.phase_step = cfg_data[mcg_pkg::STEP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.play_enable      <= 1'b0;
            cfg_reg.click_enable     <= 1'b1;
            cfg_reg.samples_per_beat <= mcg_pkg::SPB_RESET;
            cfg_reg.burst_length     <= mcg_pkg::BURST_RESET;
            cfg_reg.envelope_scale   <= mcg_pkg::SCALE_RESET;
            cfg_reg.phase_step       <= mcg_pkg::STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

@@ rtl/metronome_click_generator.sv @@
// Metronome click generator. Each input beat is one audio sample period and yields exactly
// one output beat: a Q15 click sample and a beat_start flag. While play_enable and
// click_enable are both set, a beat countdown runs; when it reaches zero or below, a burst
// of burst_length samples starts. During a burst the sample is a sine from a PHASE_BITS
// phase accumulator through a quarter-wave table, scaled by 0.25 and by a linear decay
// envelope. A sounding sample passes the envelope product through a bit-serial multiplier,
// hands it over to a second bit-serial multiplier for the sample product, stores the rounded
// sample, loads the output register and then accepts the next input. A silent sample goes
// straight to the output register. The next input is taken while a finished sample still
// waits at the output. Configuration writes are taken in any cycle and must only be issued
// while the block is idle.
module metronome_click_generator #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int PHASE_BITS       = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mcg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               restart,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [mcg_pkg::SAMPLE_W-1:0] audio_sample,
    output logic                               beat_start
);

    localparam int TAB_D  = 1 << ($clog2(SINE_TABLE_DEPTH + 1) - 1);
    localparam int TAB_B  = $clog2(TAB_D);
    localparam int ADDR_W = TAB_B + 1;
    localparam int PW     = PHASE_BITS;
    localparam int ENV_PW = mcg_pkg::SCALE_W + mcg_pkg::BURST_W;
    localparam int MUL_PW = mcg_pkg::SINE_W + mcg_pkg::ENV_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ENV  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    mcg_pkg::cfg_t cfg;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic [mcg_pkg::CD_W-1:0]    cd_reg;
    logic [mcg_pkg::CD_W-1:0]    cd_next;
    logic [mcg_pkg::BURST_W-1:0] rem_reg;
    logic [mcg_pkg::BURST_W-1:0] rem_next;
    logic [PW-1:0]               ph_reg;
    logic [PW-1:0]               ph_next;

    logic [mcg_pkg::CD_W-1:0]    cd0;
    logic [mcg_pkg::BURST_W-1:0] rem0;
    logic [mcg_pkg::BURST_W-1:0] rem1;
    logic [PW-1:0]               ph0;
    logic [mcg_pkg::SPB_W-1:0]   spb_eff;
    logic                        active;
    logic                        fire;
    logic                        sounding;
    logic                        item_go;

    logic [1:0]        quad;
    logic [TAB_B-1:0]  idx_raw;
    logic [ADDR_W-1:0] rom_addr;
    logic [mcg_pkg::SINE_W-1:0] rom_data;

    logic              env_start;
    logic              env_done;
    logic [ENV_PW-1:0] env_prod;
    logic [mcg_pkg::ENV_W-1:0] env_sat;
    logic              mul_start;
    logic              mul_done;
    logic [MUL_PW-1:0] mul_prod;
    logic [MUL_PW-1:0] rounded;
    logic [mcg_pkg::MAG_W-1:0]    mag;
    logic [mcg_pkg::SAMPLE_W-1:0] sample_calc;

    logic                         neg_reg;
    logic                         started_reg;
    logic [mcg_pkg::SAMPLE_W-1:0] sample_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [mcg_pkg::SAMPLE_W-1:0] audio_reg;
    logic                         beat_reg;
    logic                         out_load;

    mcg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign item_go  = in_valid && in_ready;

    // Apply restart, then step the beat countdown, burst count and phase
    always_comb
    begin
        cd0      = restart ? '0 : cd_reg;
        rem0     = restart ? '0 : rem_reg;
        ph0      = restart ? '0 : ph_reg;
        active   = cfg.play_enable && cfg.click_enable;
        fire     = cd0[mcg_pkg::CD_W-1] || (cd0 == '0);
        spb_eff  = (cfg.samples_per_beat == '0) ? mcg_pkg::SPB_W'(1)
                                                : cfg.samples_per_beat;
        rem1     = (active && fire) ? cfg.burst_length : rem0;
        sounding = active && (rem1 != '0);
        cd_next  = cd0;
        rem_next = rem0;
        ph_next  = ph0;
        if (active)
        begin
            cd_next  = cd0 + (fire ? mcg_pkg::CD_W'(spb_eff) : '0) - mcg_pkg::CD_W'(1);
            rem_next = sounding ? rem1 - 1'b1 : rem1;
            ph_next  = sounding ? ph0 + PW'(cfg.phase_step) : ph0;
        end
    end

    // Quarter-wave addressing: odd quadrants mirror the index
    assign quad     = ph0[PW-1 -: 2];
    assign idx_raw  = ph0[PW-3 -: TAB_B];
    assign rom_addr = quad[0] ? ADDR_W'(TAB_D) - {1'b0, idx_raw} : {1'b0, idx_raw};

    mcg_sine_rom #(
        .DEPTH (TAB_D)
    ) u_rom (
        .clk  (clk),
        .en   (item_go),
        .addr (rom_addr),
        .data (rom_data)
    );

    // Envelope: remaining count times reciprocal, saturated at 1.0
    assign env_start = item_go && sounding;

    mcg_serial_mul #(
        .AW (mcg_pkg::SCALE_W),
        .BW (mcg_pkg::BURST_W)
    ) u_env_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (env_start),
        .a       (cfg.envelope_scale),
        .b       (rem1),
        .done    (env_done),
        .product (env_prod)
    );

    assign env_sat = (env_prod > ENV_PW'(mcg_pkg::ENV_ONE)) ? mcg_pkg::ENV_ONE
                                                            : env_prod[mcg_pkg::ENV_W-1:0];

    // Sample: sine magnitude times envelope, quarter scale, round half away from zero
    assign mul_start = (state_reg == S_ENV) && env_done;

    mcg_serial_mul #(
        .AW (mcg_pkg::SINE_W),
        .BW (mcg_pkg::ENV_W)
    ) u_smp_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (rom_data),
        .b       (env_sat),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign rounded     = mul_prod + MUL_PW'(32'h20000);
    assign mag         = rounded[MUL_PW-1 -: mcg_pkg::MAG_W];
    assign sample_calc = neg_reg ? -{1'b0, mag} : {1'b0, mag};

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (item_go)
                begin
                    state_next = sounding ? S_ENV : S_DONE;
                end
            S_ENV:
                if (env_done)
                begin
                    state_next = S_MUL;
                end
            S_MUL:
                if (mul_done)
                begin
                    state_next = S_DONE;
                end
            S_DONE:
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign out_load       = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cd_reg        <= '0;
            rem_reg       <= '0;
            ph_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (item_go)
            begin
                cd_reg  <= cd_next;
                rem_reg <= rem_next;
                ph_reg  <= ph_next;
            end
        end
    end

    // Hold per-sample results until the output register takes them
    always_ff @(posedge clk)
    begin
        if (item_go)
        begin
            neg_reg     <= quad[1];
            started_reg <= active && fire;
            sample_reg  <= '0;
        end
        else if ((state_reg == S_MUL) && mul_done)
        begin
            sample_reg <= sample_calc;
        end
        if (out_load)
        begin
            audio_reg <= sample_reg;
            beat_reg  <= started_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign audio_sample = audio_reg;
    assign beat_start   = beat_reg;

    // One sample in flight: an accepted beat always leaves idle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_go |=> state_reg != S_IDLE)
        else $error("sequencer stayed idle after accepting a sample");

    // A finished sample waits while the output register is still occupied
    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && out_valid_reg && !out_ready |=> state_reg == S_DONE)
        else $error("result overwrote an untaken output beat");

    // Quarter scale keeps the magnitude within 8192
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) && mul_done |-> mag <= mcg_pkg::MAG_W'(8192))
        else $error("sample magnitude out of range");

    // Restart while stopped leaves all counters and the phase cleared
    a_restart_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_go && restart && !(cfg.play_enable && cfg.click_enable)
        |=> (cd_reg == '0) && (rem_reg == '0) && (ph_reg == '0))
        else $error("restart did not clear state");

endmodule
